@@ rtl/core/ffra_pkg.sv @@
// shared types and constants of the first-fit region allocator
package ffra_pkg;

   // default pool shape
   localparam int unsigned REGION_BYTES_DEF = 32'd67108864;
   localparam int unsigned MAX_REGIONS_DEF  = 16;

   // fixed field widths
   localparam int unsigned BLOB_W     = 27;
   localparam int unsigned SEC24_W    = 24;
   localparam int unsigned SEC_W      = 32;
   localparam int unsigned OFS_W      = 25;
   localparam int unsigned REG_IDX_W  = 4;
   localparam int unsigned START_W    = 28;
   localparam int unsigned REQ_DATA_W = 144;
   localparam int unsigned RSP_DATA_W = 152;

   localparam logic [SEC_W-1:0] ABSENT_MARK = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_SIZE  = 2'd1,
      STATUS_POOL_FULL = 2'd2
   } status_type;

   // finished allocation handed from the controller to the output stage
   typedef struct packed {
      status_type             status;
      logic [REG_IDX_W-1:0]   region_index;
      logic                   opened;
      logic                   short_idx;
      logic [START_W-1:0]     start;
      logic [SEC24_W-1:0]     pos_words;
      logic [SEC24_W-1:0]     nrm_words;
      logic [SEC_W-1:0]       tan_words;
      logic [SEC_W-1:0]       uv_words;
   } alloc_result_type;

endpackage

@@ rtl/core/first_fit_region_allocator.sv @@
// top level of the first-fit region allocator
//
// Places byte blobs into a pool of MAX_REGIONS regions of REGION_BYTES each.
// One request transfer on req_ (blob size, section offsets, index width in
// req_tuser) gives exactly one response transfer on rsp_ with status, region,
// index offset and the four section offsets moved into the region.
// The remaining byte counts live in a single-port-read memory; the open
// regions are read one per cycle in index order, the first with room wins,
// and the updated count is written back before the next request is taken.
// A bad size goes straight to the output stage. Otherwise the open regions
// are scanned, a new region is opened when none fits, and the room write-back
// and start calculation come before the hand-over; a full pool hands over its
// status without a write-back. A request is taken only after the previous one
// has reached the output register.
// Reset empties the pool at once; the room memory needs no clearing.
// A finished result waits in the output register while rsp_tready is low;
// the next request is then taken and worked on, and holds only at its end.
module first_fit_region_allocator #(
   parameter int unsigned REGION_BYTES = ffra_pkg::REGION_BYTES_DEF,
   parameter int unsigned MAX_REGIONS  = ffra_pkg::MAX_REGIONS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // blob_bytes, pos_words, nrm_words, tan_words, uv_words, zero fill
   input  logic [ffra_pkg::REQ_DATA_W-1:0]    req_tdata,
   // short_indices
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status, region_index, opened_region, index_offset, pos_offset,
   // nrm_offset, tan_offset, uv_offset, zero fill
   output logic [ffra_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import ffra_pkg::*;

   alloc_result_type cmd;
   logic             cmd_valid;
   logic             cmd_ready;

   ffra_ctrl #(
      .REGION_BYTES(REGION_BYTES),
      .MAX_REGIONS (MAX_REGIONS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .blob_bytes   (req_tdata[26:0]),
      .short_indices(req_tuser),
      .pos_words    (req_tdata[50:27]),
      .nrm_words    (req_tdata[74:51]),
      .tan_words    (req_tdata[106:75]),
      .uv_words     (req_tdata[138:107]),
      .cmd_valid    (cmd_valid),
      .cmd_ready    (cmd_ready),
      .cmd          (cmd)
   );

   ffra_out u_out (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

@@ rtl/core/ffra_room_ram.sv @@
// remaining-byte memory, one entry per region, registered read
module ffra_room_ram #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned WIDTH = 27,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ffra_ctrl.sv @@
// request sequencer: region scan, region opening and room write-back
module ffra_ctrl #(
   parameter int unsigned REGION_BYTES = ffra_pkg::REGION_BYTES_DEF,
   parameter int unsigned MAX_REGIONS  = ffra_pkg::MAX_REGIONS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ffra_pkg::BLOB_W-1:0]     blob_bytes,
   input  logic                            short_indices,
   input  logic [ffra_pkg::SEC24_W-1:0]    pos_words,
   input  logic [ffra_pkg::SEC24_W-1:0]    nrm_words,
   input  logic [ffra_pkg::SEC_W-1:0]      tan_words,
   input  logic [ffra_pkg::SEC_W-1:0]      uv_words,
   output logic                            cmd_valid,
   input  logic                            cmd_ready,
   output ffra_pkg::alloc_result_type      cmd
);
   import ffra_pkg::*;

   localparam int unsigned ROOM_W = $clog2(REGION_BYTES + 1);
   localparam int unsigned CNT_W  = $clog2(MAX_REGIONS + 1);
   localparam int unsigned ADDR_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int unsigned CMP_W  = (ROOM_W > BLOB_W) ? ROOM_W : BLOB_W;
   localparam logic [ROOM_W-1:0] FULL_ROOM = ROOM_W'(REGION_BYTES);
   localparam logic [CNT_W-1:0]  POOL_MAX  = CNT_W'(MAX_REGIONS);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_CALC = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [BLOB_W-1:0]    size_ff, size_in;
   logic                 short_ff, short_in;
   logic [SEC24_W-1:0]   pos_ff, pos_in;
   logic [SEC24_W-1:0]   nrm_ff, nrm_in;
   logic [SEC_W-1:0]     tan_ff, tan_in;
   logic [SEC_W-1:0]     uv_ff, uv_in;
   logic [CNT_W-1:0]     open_cnt_ff, open_cnt_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [CNT_W-1:0]     chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]     pick_ff, pick_in;
   logic [ROOM_W-1:0]    room_ff, room_in;
   logic                 opened_ff, opened_in;
   status_type           status_ff, status_in;
   logic [START_W-1:0]   start_ff, start_in;

   logic                 rd_en;
   logic [ROOM_W-1:0]    rd_data;
   logic                 wr_en;
   logic [ROOM_W-1:0]    wr_data;
   logic                 size_bad;
   logic                 fit;
   logic                 scan_done;

   ffra_room_ram #(
      .DEPTH (MAX_REGIONS),
      .WIDTH (ROOM_W),
      .ADDR_W(ADDR_W)
   ) u_room_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(pick_ff[ADDR_W-1:0]),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(issue_ff[ADDR_W-1:0]),
      .rd_data(rd_data)
   );

   // request checks and scan status
   assign size_bad  = (blob_bytes == '0) ||
                      (32'(blob_bytes) > 32'(REGION_BYTES));
   assign fit       = chk_valid_ff && (CMP_W'(rd_data) >= CMP_W'(size_ff));
   assign scan_done = !chk_valid_ff && (issue_ff >= open_cnt_ff);
   assign rd_en     = (state_ff == S_SCAN) && !fit && (issue_ff < open_cnt_ff);
   assign wr_en     = (state_ff == S_CALC);
   assign wr_data   = room_ff - ROOM_W'(size_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign cmd_valid = (state_ff == S_EMIT);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      short_in     = short_ff;
      pos_in       = pos_ff;
      nrm_in       = nrm_ff;
      tan_in       = tan_ff;
      uv_in        = uv_ff;
      open_cnt_in  = open_cnt_ff;
      issue_in     = issue_ff;
      chk_valid_in = rd_en;
      chk_idx_in   = issue_ff;
      pick_in      = pick_ff;
      room_in      = room_ff;
      opened_in    = opened_ff;
      status_in    = status_ff;
      start_in     = start_ff;
      if (rd_en) begin
         issue_in = issue_ff + CNT_W'(1);
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               size_in   = blob_bytes;
               short_in  = short_indices;
               pos_in    = pos_words;
               nrm_in    = nrm_words;
               tan_in    = tan_words;
               uv_in     = uv_words;
               issue_in  = '0;
               opened_in = 1'b0;
               if (size_bad) begin
                  status_in = STATUS_BAD_SIZE;
                  state_in  = S_EMIT;
               end else begin
                  status_in = STATUS_OK;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (fit) begin
               pick_in   = chk_idx_ff;
               room_in   = rd_data;
               opened_in = 1'b0;
               state_in  = S_CALC;
            end else if (scan_done) begin
               if (open_cnt_ff == POOL_MAX) begin
                  status_in = STATUS_POOL_FULL;
                  state_in  = S_EMIT;
               end else begin
                  pick_in   = open_cnt_ff;
                  room_in   = FULL_ROOM;
                  opened_in = 1'b1;
                  state_in  = S_CALC;
               end
            end
         end
         S_CALC: begin
            start_in = START_W'(FULL_ROOM - room_ff);
            if (opened_ff) begin
               open_cnt_in = open_cnt_ff + CNT_W'(1);
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (cmd_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         open_cnt_ff  <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_cnt_ff  <= open_cnt_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   // working registers of the current request
   always_ff @(posedge clock) begin
      size_ff    <= size_in;
      short_ff   <= short_in;
      pos_ff     <= pos_in;
      nrm_ff     <= nrm_in;
      tan_ff     <= tan_in;
      uv_ff      <= uv_in;
      issue_ff   <= issue_in;
      chk_idx_ff <= chk_idx_in;
      pick_ff    <= pick_in;
      room_ff    <= room_in;
      opened_ff  <= opened_in;
      status_ff  <= status_in;
      start_ff   <= start_in;
   end

   // allocation handed to the output stage
   always_comb begin
      cmd.status       = status_ff;
      cmd.region_index = REG_IDX_W'(pick_ff);
      cmd.opened       = opened_ff;
      cmd.short_idx    = short_ff;
      cmd.start        = start_ff;
      cmd.pos_words    = pos_ff;
      cmd.nrm_words    = nrm_ff;
      cmd.tan_words    = tan_ff;
      cmd.uv_words     = uv_ff;
   end

endmodule

@@ rtl/core/ffra_out.sv @@
// offset arithmetic and result register
module ffra_out (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_valid,
   output logic                               cmd_ready,
   input  ffra_pkg::alloc_result_type         cmd,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ffra_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import ffra_pkg::*;

   localparam int unsigned PAD_W = RSP_DATA_W - (2 + REG_IDX_W + 1 + 3 * OFS_W + 2 * SEC_W);

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                   ok;
   logic [START_W-3:0]     base4;
   logic [OFS_W-1:0]       idx_ofs;
   logic [SEC_W-1:0]       pos_sum;
   logic [SEC_W-1:0]       nrm_sum;
   logic [SEC_W-1:0]       tan_ofs;
   logic [SEC_W-1:0]       uv_ofs;

   assign cmd_ready = !rsp_valid_ff || rsp_tready;

   // section offsets shifted by the start word
   always_comb begin
      ok      = (cmd.status == STATUS_OK);
      base4   = cmd.start[START_W-1:2];
      idx_ofs = cmd.short_idx ? OFS_W'(cmd.start[START_W-1:1]) : OFS_W'(base4);
      pos_sum = SEC_W'(cmd.pos_words) + SEC_W'(base4);
      nrm_sum = SEC_W'(cmd.nrm_words) + SEC_W'(base4);
      tan_ofs = (cmd.tan_words == ABSENT_MARK) ? ABSENT_MARK
                                                : cmd.tan_words + SEC_W'(base4);
      uv_ofs  = (cmd.uv_words == ABSENT_MARK) ? ABSENT_MARK
                                               : cmd.uv_words + SEC_W'(base4);
      if (ok) begin
         rsp_data_in = {PAD_W'(0), uv_ofs, tan_ofs, nrm_sum[OFS_W-1:0],
                        pos_sum[OFS_W-1:0], idx_ofs, cmd.opened,
                        cmd.region_index, cmd.status};
      end else begin
         rsp_data_in = {(RSP_DATA_W-2)'(0), cmd.status};
      end
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd_valid && cmd_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_valid && cmd_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/core/ffra_checker.sv @@
// port-level checks of the allocator, bound to the top level
module ffra_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [ffra_pkg::REQ_DATA_W-1:0]    req_tdata,
   input logic                               req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [ffra_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import ffra_pkg::*;

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // one request at a time: a request transfer closes the input
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

   // an error response carries nothing but its status
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != STATUS_OK) |-> (rsp_tdata[RSP_DATA_W-1:2] == '0))
      else $error("error response with nonzero fields");

   // status code is never the unused one
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'b11))
      else $error("invalid status code");

endmodule

bind first_fit_region_allocator ffra_checker u_ffra_checker (.*);
